[design/ple_pkg.sv]
// Shared types and codes for the positional list engine.
package ple_pkg;

	localparam int POS_W = 8;
	localparam int DATA_W = 32;
	localparam int LEN_W = 6;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_READ   = 2'd3
	} ple_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ple_status_t;

	typedef struct packed {
		ple_kind_t                 kind;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} ple_req_t;

	typedef struct packed {
		ple_status_t               status;
		logic signed [DATA_W-1:0]  read_value;
		logic [LEN_W-1:0]          length;
	} ple_rsp_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic                      ins;
		logic                      del;
		logic [POS_W-1:0]          slot;
		logic signed [DATA_W-1:0]  value;
	} ple_cmd_t;

endpackage

[design/ple_cell.sv]
// One storage cell of the list row: holds one item and shifts with its neighbors.
module ple_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  ple_pkg::ple_cmd_t                 cmd,
	input  logic signed [ple_pkg::DATA_W-1:0] left_item,
	input  logic signed [ple_pkg::DATA_W-1:0] right_item,
	output logic signed [ple_pkg::DATA_W-1:0] item
);
	import ple_pkg::*;

	logic signed [DATA_W-1:0] item_q;
	logic                     hit;
	logic                     above;

	// The cell compares its own index with the slot of the operation.
	assign hit   = (cmd.slot == POS_W'(IDX));
	assign above = (cmd.slot < POS_W'(IDX));

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (hit) begin
				item_q <= cmd.value;
			end else if (above) begin
				item_q <= left_item;
			end
		end else if (cmd.del && (hit || above)) begin
			item_q <= right_item;
		end
	end

	assign item = item_q;

endmodule

[design/ple_row.sv]
// Row of list cells with the neighbor wiring and the read selection.
module ple_row #(
	parameter int CAPACITY = 32
) (
	input  logic                              clk,
	input  ple_pkg::ple_cmd_t                 cmd,
	output logic signed [ple_pkg::DATA_W-1:0] rd_item
);
	import ple_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic signed [DATA_W-1:0] items [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_item;
		logic signed [DATA_W-1:0] right_item;

		// The end cells never take from outside the row; they see themselves.
		if (i == 0) begin : g_first
			assign left_item = items[i];
		end else begin : g_mid_l
			assign left_item = items[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_item = items[i];
		end else begin : g_mid_r
			assign right_item = items[i+1];
		end

		ple_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_item  (left_item),
			.right_item (right_item),
			.item       (items[i])
		);
	end

	assign rd_item = items[cmd.slot[AW-1:0]];

endmodule

[design/positional_list_engine_unit.sv]
// Top level of the positional list engine: control, length counter and result register.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit items,
// addressed by 1-based positions, in a row of cells that each hold one item.
// Every accepted request beat (append, insert before a position, delete at a
// position, or read at a position) finishes in the cycle it is accepted: all
// cells compare their own index with the target slot at once and either keep
// their item, load the new value, or take the item of the left or right
// neighbor. The engine therefore takes one request per clock, and its result
// beat appears on the response channel in the cycle after acceptance. The only
// thing that holds requests back is a response beat that is still stalled,
// since the single result register must be free or emptying. The result
// carries a status (ok, position out of range, or store full), the item read
// by a successful read (zero otherwise) and the list length after the
// operation. After reset the list is empty; the stored items need no clearing
// because a position check keeps every read inside the written part.
module positional_list_engine_unit #(
	parameter int CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ple_pkg::ple_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ple_pkg::ple_rsp_t rsp
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_next;
	logic                     rsp_valid_q;
	ple_rsp_t                 rsp_q;

	logic                     accept;
	logic [POS_W:0]           pos_ext;
	logic [POS_W:0]           cnt_ext;
	logic                     pos_zero;
	logic                     ins_in_range;
	logic                     rd_in_range;
	logic                     full;
	logic                     do_ins;
	logic                     do_del;
	logic                     do_rd;
	ple_status_t              status;
	ple_cmd_t                 cmd;
	logic signed [DATA_W-1:0] rd_item;

	// A new beat is taken whenever the result register is empty or is being
	// emptied in this cycle.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// Range checks are made one bit wider so that length plus one never wraps.
	assign pos_ext      = {1'b0, req.position};
	assign cnt_ext      = (POS_W + 1)'(count_q);
	assign pos_zero     = (req.position == '0);
	assign ins_in_range = !pos_zero && (pos_ext <= cnt_ext + 1'b1);
	assign rd_in_range  = !pos_zero && (pos_ext <= cnt_ext);
	assign full         = (cnt_ext == (POS_W + 1)'(CAPACITY));

	always_comb begin
		do_ins   = 1'b0;
		do_del   = 1'b0;
		do_rd    = 1'b0;
		status   = ST_OK;
		cmd.slot = req.position - 1'b1;
		unique case (req.kind)
			KIND_APPEND: begin
				// An append is an insert at the slot just past the last item.
				cmd.slot = POS_W'(count_q);
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			KIND_INSERT: begin
				if (!ins_in_range) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			KIND_DELETE: begin
				if (!rd_in_range) begin
					status = ST_RANGE;
				end else begin
					do_del = 1'b1;
				end
			end
			KIND_READ: begin
				if (!rd_in_range) begin
					status = ST_RANGE;
				end else begin
					do_rd = 1'b1;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
		cmd.ins   = accept && do_ins;
		cmd.del   = accept && do_del;
		cmd.value = req.value;
	end

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + 1'b1;
		end else if (do_del) begin
			count_next = count_q - 1'b1;
		end
	end

	ple_row #(
		.CAPACITY(CAPACITY)
	) u_row (
		.clk     (clk),
		.cmd     (cmd),
		.rd_item (rd_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The result payload needs no reset; it is only looked at with its valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status     <= status;
			rsp_q.read_value <= do_rd ? rd_item : '0;
			rsp_q.length     <= LEN_W'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/ple_checker.sv]
// Port-level checker for the positional list engine and its bind to the top level.
module ple_checker #(
	parameter int CAPACITY = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input ple_pkg::ple_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input ple_pkg::ple_rsp_t rsp
);
	import ple_pkg::*;

	logic req_acc;

	assign req_acc = req_valid && !req_stall;

	// A stalled response beat holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Every accepted request shows its result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("no response one cycle after an accepted request");

	// A failed operation never returns data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
		else $error("failed operation returned nonzero data");

	// A full report comes only with the list at capacity.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.length == LEN_W'(CAPACITY))
		else $error("store full reported below capacity");

	// An append ignores its position and never reports a range error.
	a_append_range: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.kind == KIND_APPEND |=> rsp.status != ST_RANGE)
		else $error("append reported a range error");

endmodule

bind positional_list_engine_unit ple_checker #(
	.CAPACITY(CAPACITY)
) u_ple_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
